>>> hdl/whs_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the wave height field stepper
// no dependencies
package whs_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int PASSES_DEF     = 3;

  localparam int MIN_POINTS   = 5;
  localparam int EDGE_POINTS  = 2;
  localparam int STENCIL_SPAN = 4;
  localparam int POINTS_W     = 9;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 25;

  localparam logic [CFG_IW-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DAMP   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_POINTS = 2'd2;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  localparam logic [15:0]         GAIN_RST   = 16'd6554;
  localparam logic [24:0]         DAMP_RST   = 25'd16777048;
  localparam logic [24:0]         DAMP_ONE   = 25'd16777216;
  localparam logic [POINTS_W-1:0] POINTS_RST = 9'd256;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         index;
    logic signed [15:0] value;
    logic [15:0]        delta;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               status;
  } rsp_t;

  typedef struct packed {
    logic wr_both;
    logic wr_prv;
    logic a_cur;
  } mem_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FACTOR,
    ST_SCAN,
    ST_DRAIN
  } state_e;

endpackage

>>> hdl/wave_heightfield_step.sv
`timescale 1ns / 1ps
// damped 1-d wave height field: sample store, read-back and leapfrog time step
// depends on whs_pkg, whs_field_mem and whs_stencil_dp
//
// usage
//   commands arrive on cmd_i and are taken when start is high and busy low
//   each command gives exactly one result on res_o, marked by res_valid_o for
//   one cycle; the receiver cannot stall, so results are simply presented
//   write, bad index and unused mode: result the cycle after acceptance,
//   a new command may be taken in that same cycle
//   read: the sample passes the memory read register, then the result register
//   advance: PASSES passes, n the clamped point count; each pass streams the
//   current buffer's n points through one memory read port at one point per
//   cycle, then waits for the update pipeline to drain before the buffers swap
//   configuration transactions are accepted on every cycle and must only be
//   issued while the block is idle
//   after reset both buffers are cleared one entry per cycle, all MAX_POINTS
//   entries, with busy high; configuration returns to its default values
module wave_heightfield_step import whs_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int PASSES     = PASSES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd_i,
  output rsp_t              res_o,
  output logic              res_valid_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (NW > POINTS_W) ? NW : POINTS_W;
  localparam int PW = (PASSES > 1) ? $clog2(PASSES) : 1;

  state_e state_q, state_d;

  logic [15:0]         gain_q;
  logic [24:0]         damp_q;
  logic [POINTS_W-1:0] pts_q;

  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [PW-1:0] pass_q, pass_d;
  logic          a_cur_q, a_cur_d;
  logic [15:0]   delta_q, delta_d;
  logic [15:0]   factor_q, factor_d;
  rsp_t          res_q, res_d;
  logic          res_vld_q, res_vld_d;

  logic [NW-1:0] n_eff;
  logic [CW-1:0] pts_w;
  logic [AW-1:0] n_last;
  logic [24:0]   damp_eff;
  logic [32:0]   fprod;
  logic [24:0]   fshift;
  logic          accept;
  logic          idx_ok;
  logic [AW-1:0] idx_addr;

  mem_cmd_t           mcmd;
  logic [AW-1:0]      cur_addr, prv_addr, wr_addr;
  logic signed [15:0] wr_data, cur_data, prv_data;
  logic               issue, issue_ctr;
  logic               dp_wr_vld, dp_busy;
  logic [AW-1:0]      dp_wr_addr;
  logic signed [15:0] dp_wr_data;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      damp_q <= DAMP_RST;
      pts_q  <= POINTS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GAIN:   gain_q <= cfg_data_i[15:0];
        CFG_DAMP:   damp_q <= cfg_data_i[24:0];
        CFG_POINTS: pts_q  <= cfg_data_i[POINTS_W-1:0];
        default:    ;
      endcase
    end
  end

  assign pts_w = CW'(pts_q);

  always_comb begin
    if (pts_w < CW'(MIN_POINTS)) begin
      n_eff = NW'(MIN_POINTS);
    end else if (pts_w > CW'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = pts_w[NW-1:0];
    end
  end

  assign n_last   = AW'(n_eff - NW'(1));
  assign damp_eff = (damp_q > DAMP_ONE) ? DAMP_ONE : damp_q;
  assign fprod    = 33'(gain_q) * 33'(delta_q) + 33'd128;
  assign fshift   = fprod[32:8];

  assign accept   = start && !busy;
  assign idx_ok   = CW'(cmd_i.index) < CW'(n_eff);
  assign idx_addr = AW'(cmd_i.index);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      k_q       <= '0;
      clr_q     <= '0;
      pass_q    <= '0;
      a_cur_q   <= 1'b1;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      clr_q     <= clr_d;
      pass_q    <= pass_d;
      a_cur_q   <= a_cur_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q  <= delta_d;
    factor_q <= factor_d;
    res_q    <= res_d;
  end

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    clr_d        = clr_q;
    pass_d       = pass_q;
    a_cur_d      = a_cur_q;
    delta_d      = delta_q;
    factor_d     = factor_q;
    res_d        = res_q;
    res_vld_d    = 1'b0;
    issue        = 1'b0;
    issue_ctr    = 1'b0;
    cur_addr     = k_q;
    prv_addr     = AW'(k_q - AW'(EDGE_POINTS));
    wr_addr      = dp_wr_addr;
    wr_data      = dp_wr_data;
    mcmd.wr_both = 1'b0;
    mcmd.wr_prv  = dp_wr_vld;
    mcmd.a_cur   = a_cur_q;

    unique case (state_q)
      ST_CLEAR: begin
        mcmd.wr_both = 1'b1;
        wr_addr      = clr_q;
        wr_data      = '0;
        if (clr_q == AW'(MAX_POINTS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        cur_addr = idx_addr;
        if (accept) begin
          unique case (cmd_i.mode)
            MODE_WRITE: begin
              mcmd.wr_both = idx_ok;
              wr_addr      = idx_addr;
              wr_data      = cmd_i.value;
              res_d        = '{sample: '0, status: !idx_ok};
              res_vld_d    = 1'b1;
            end
            MODE_READ: begin
              if (idx_ok) begin
                state_d = ST_READ;
              end else begin
                res_d     = '{sample: '0, status: 1'b1};
                res_vld_d = 1'b1;
              end
            end
            MODE_ADVANCE: begin
              delta_d = cmd_i.delta;
              state_d = ST_FACTOR;
            end
            default: begin
              res_d     = '{sample: '0, status: 1'b0};
              res_vld_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_d     = '{sample: cur_data, status: 1'b0};
        res_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_FACTOR: begin
        factor_d = (|fshift[24:16]) ? 16'hffff : fshift[15:0];
        k_d      = '0;
        pass_d   = '0;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        issue     = 1'b1;
        issue_ctr = k_q >= AW'(STENCIL_SPAN);
        if (k_q == n_last) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!dp_busy) begin
          a_cur_d = !a_cur_q;
          k_d     = '0;
          if (pass_q == PW'(PASSES - 1)) begin
            res_d     = '{sample: '0, status: 1'b0};
            res_vld_d = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            pass_d  = pass_q + PW'(1);
            state_d = ST_SCAN;
          end
        end
      end
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

  whs_field_mem #(
    .MAX_POINTS (MAX_POINTS)
  ) u_mem (
    .clk_i      (clk_i),
    .cmd_i      (mcmd),
    .cur_addr_i (cur_addr),
    .prv_addr_i (prv_addr),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .cur_data_o (cur_data),
    .prv_data_o (prv_data)
  );

  whs_stencil_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .issue_ctr_i (issue_ctr),
    .ctr_addr_i  (prv_addr),
    .cur_data_i  (cur_data),
    .prv_data_i  (prv_data),
    .factor_i    (factor_q),
    .damp_i      (damp_eff),
    .wr_vld_o    (dp_wr_vld),
    .wr_addr_o   (dp_wr_addr),
    .wr_data_o   (dp_wr_data),
    .busy_o      (dp_busy)
  );

`ifndef ASSERT_OFF
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !dp_busy)
    else $error("update pipeline active while idle");

  a_wb_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_wr_vld |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("stencil write back outside a pass");

  a_advance_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.mode == MODE_ADVANCE) |=> (busy && !res_valid_o))
    else $error("advance not taken up");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.mode != MODE_ADVANCE && (cmd_i.mode != MODE_READ || !idx_ok))
      |=> res_valid_o)
    else $error("missing single cycle result");

  a_swap_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_cur_q != $past(a_cur_q)) |-> ($past(state_q) == ST_DRAIN && !$past(dp_busy)))
    else $error("buffer swap with pipeline in flight");
`endif

endmodule

>>> hdl/whs_field_mem.sv
`timescale 1ns / 1ps
// current and previous height buffers, one read and one write port each
// depends on whs_pkg for the command struct
module whs_field_mem import whs_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic                 clk_i,
  input  mem_cmd_t             cmd_i,
  input  logic [AW-1:0]        cur_addr_i,
  input  logic [AW-1:0]        prv_addr_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic signed [15:0]   wr_data_i,
  output logic signed [15:0]   cur_data_o,
  output logic signed [15:0]   prv_data_o
);

  logic signed [15:0] mem_a [MAX_POINTS];
  logic signed [15:0] mem_b [MAX_POINTS];

  logic [AW-1:0]      a_rd_addr;
  logic [AW-1:0]      b_rd_addr;
  logic               we_a;
  logic               we_b;
  logic signed [15:0] a_rd_q;
  logic signed [15:0] b_rd_q;
  logic               sel_q;

  assign a_rd_addr = cmd_i.a_cur ? cur_addr_i : prv_addr_i;
  assign b_rd_addr = cmd_i.a_cur ? prv_addr_i : cur_addr_i;
  assign we_a = cmd_i.wr_both | (cmd_i.wr_prv & ~cmd_i.a_cur);
  assign we_b = cmd_i.wr_both | (cmd_i.wr_prv & cmd_i.a_cur);

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wr_addr_i] <= wr_data_i;
    end
    a_rd_q <= mem_a[a_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[wr_addr_i] <= wr_data_i;
    end
    b_rd_q <= mem_b[b_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    sel_q <= cmd_i.a_cur;
  end

  assign cur_data_o = sel_q ? a_rd_q : b_rd_q;
  assign prv_data_o = sel_q ? b_rd_q : a_rd_q;

endmodule

>>> hdl/whs_stencil_dp.sv
`timescale 1ns / 1ps
// five point window and leapfrog update pipeline, one point per cycle
// depends on whs_pkg; fed by whs_field_mem read data
module whs_stencil_dp import whs_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               issue_i,
  input  logic               issue_ctr_i,
  input  logic [AW-1:0]      ctr_addr_i,
  input  logic signed [15:0] cur_data_i,
  input  logic signed [15:0] prv_data_i,
  input  logic [15:0]        factor_i,
  input  logic [24:0]        damp_i,
  output logic               wr_vld_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic signed [15:0] wr_data_o,
  output logic               busy_o
);

  localparam logic signed [35:0] RND_FACTOR = 36'sd32768;
  localparam logic signed [46:0] RND_DAMP   = 47'sd8388608;

  // stage valids
  logic rd_any_q, rd_ctr_q, s_vld_q, p_vld_q, v_vld_q, m_vld_q;

  logic [AW-1:0]      rd_addr_q, s_addr_q, p_addr_q, v_addr_q, m_addr_q;
  logic signed [15:0] win_q [4];
  logic signed [18:0] sum_d, s_q;
  logic signed [15:0] s_h_q, s_p_q, p_h_q, p_p_q;
  logic signed [35:0] prod_d, prod_q, prod_rnd;
  logic signed [20:0] v_d, v_q;
  logic signed [46:0] m_d, m_q, m_rnd;
  logic signed [22:0] r_val;

  assign sum_d = 19'(win_q[0]) + 19'(win_q[1]) + 19'(win_q[3]) + 19'(cur_data_i)
               - (19'(win_q[2]) <<< 2);

  assign prod_d   = $signed({1'b0, factor_i}) * s_q;
  assign prod_rnd = prod_q + RND_FACTOR;
  assign v_d      = 21'($signed(prod_rnd[35:16])) + (21'(p_h_q) <<< 1) - 21'(p_p_q);
  assign m_d      = v_q * $signed({1'b0, damp_i});
  assign m_rnd    = m_q + RND_DAMP;
  assign r_val    = m_rnd[46:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_any_q <= 1'b0;
      rd_ctr_q <= 1'b0;
      s_vld_q  <= 1'b0;
      p_vld_q  <= 1'b0;
      v_vld_q  <= 1'b0;
      m_vld_q  <= 1'b0;
    end else begin
      rd_any_q <= issue_i;
      rd_ctr_q <= issue_i & issue_ctr_i;
      s_vld_q  <= rd_ctr_q;
      p_vld_q  <= s_vld_q;
      v_vld_q  <= p_vld_q;
      m_vld_q  <= v_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= ctr_addr_i;
    if (rd_any_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= cur_data_i;
    end
    s_q      <= sum_d;
    s_h_q    <= win_q[2];
    s_p_q    <= prv_data_i;
    s_addr_q <= rd_addr_q;
    prod_q   <= prod_d;
    p_h_q    <= s_h_q;
    p_p_q    <= s_p_q;
    p_addr_q <= s_addr_q;
    v_q      <= v_d;
    v_addr_q <= p_addr_q;
    m_q      <= m_d;
    m_addr_q <= v_addr_q;
  end

  always_comb begin
    if (r_val > 23'sd32767) begin
      wr_data_o = 16'sh7fff;
    end else if (r_val < -23'sd32768) begin
      wr_data_o = 16'sh8000;
    end else begin
      wr_data_o = r_val[15:0];
    end
  end

  assign wr_vld_o  = m_vld_q;
  assign wr_addr_o = m_addr_q;
  assign busy_o    = rd_any_q | rd_ctr_q | s_vld_q | p_vld_q | v_vld_q | m_vld_q;

endmodule

>>> verif/whs_checker.sv
`timescale 1ns / 1ps
// scoreboard for wave_heightfield_step: follows command, result and configuration
// transactions, keeps its own height field and compares every result; depends on whs_pkg
module whs_checker import whs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  cmd_t              cmd_i,
  input  rsp_t              res_i,
  input  logic              res_valid_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int PRINT_CAP = 100;

  logic [15:0]         gain_q;
  logic [24:0]         damp_q;
  logic [POINTS_W-1:0] points_q;
  // height[0] is field a, height[1] field b
  logic signed [15:0]  height [2][MAX_POINTS_DEF];
  logic                cur_is_a;
  rsp_t                awaited_rsp [$];
  int                  errors;
  int                  results_seen;

  function automatic int live_points();
    int n;
    n = int'(points_q);
    if (n < MIN_POINTS) n = MIN_POINTS;
    if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
    return n;
  endfunction

  function automatic logic signed [15:0] clip16(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return 16'(x);
  endfunction

  task automatic leapfrog_advance(input logic [15:0] dt);
    int     n;
    int     c;
    int     pv;
    int     p;
    int     i;
    longint fac;
    longint damp;
    longint h;
    longint s;
    longint v;
    n = live_points();
    damp = (damp_q > DAMP_ONE) ? longint'(DAMP_ONE) : longint'(damp_q);
    fac = (longint'(gain_q) * longint'(dt) + 128) >>> 8;
    if (fac > 65535) fac = 65535;
    for (p = 0; p < PASSES_DEF; p++) begin
      c  = cur_is_a ? 0 : 1;
      pv = 1 - c;
      for (i = EDGE_POINTS; i + EDGE_POINTS < n; i++) begin
        h = longint'(height[c][i]);
        s = longint'(height[c][i-2]) + longint'(height[c][i-1])
            + longint'(height[c][i+1]) + longint'(height[c][i+2]) - 4 * h;
        v = ((fac * s + 32768) >>> 16) + 2 * h - longint'(height[pv][i]);
        height[pv][i] = clip16((v * damp + (64'sd1 <<< 23)) >>> 24);
      end
      cur_is_a = !cur_is_a;
    end
  endtask

  task automatic predict_reply(input cmd_t c, output rsp_t r);
    int n;
    int sel;
    r   = '0;
    n   = live_points();
    sel = cur_is_a ? 0 : 1;
    case (c.mode)
      MODE_WRITE, MODE_READ: begin
        if (int'(c.index) >= n) begin
          r.status = 1'b1;
        end else if (c.mode == MODE_WRITE) begin
          height[0][c.index] = c.value;
          height[1][c.index] = c.value;
        end else begin
          r.sample = height[sel][c.index];
        end
      end
      MODE_ADVANCE: begin
        leapfrog_advance(c.delta);
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(string msg);
    if (errors < PRINT_CAP) $display("ERROR result %0d: %s", results_seen, msg);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      gain_q   = GAIN_RST;
      damp_q   = DAMP_RST;
      points_q = POINTS_RST;
      cur_is_a = 1'b1;
      for (int k = 0; k < MAX_POINTS_DEF; k++) begin
        height[0][k] = '0;
        height[1][k] = '0;
      end
      awaited_rsp.delete();
      errors       = 0;
      results_seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_valid_i) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch($sformatf("unexpected result, sample %0d status %0d",
                                    res_i.sample, res_i.status));
        end else begin
          want = awaited_rsp.pop_front();
          if (res_i.sample !== want.sample)
            report_mismatch($sformatf("sample %0d, expected %0d", res_i.sample, want.sample));
          if (res_i.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", res_i.status, want.status));
        end
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_GAIN:   gain_q   = cfg_data_i[15:0];
          CFG_DAMP:   damp_q   = cfg_data_i[24:0];
          CFG_POINTS: points_q = cfg_data_i[POINTS_W-1:0];
          default: begin
          end
        endcase
      end
      if (start_i && !busy_i) begin
        predict_reply(cmd_i, want);
        awaited_rsp.push_back(want);
      end
      fail_count_o <= errors;
      pending_o    <= awaited_rsp.size();
    end
  end

endmodule

>>> verif/tb_wave_heightfield_step.sv
`timescale 1ns / 1ps
// testbench top for wave_heightfield_step: reset, directed and random commands,
// configuration phases and the verdict; depends on whs_pkg and whs_checker
module tb_wave_heightfield_step;
  import whs_pkg::*;

  localparam logic [1:0]        MODE_UNUSED = 2'd3;
  localparam logic [CFG_IW-1:0] CFG_SPARE   = 2'd3;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 85;
  localparam int SETTLE      = PASSES_DEF * (MAX_POINTS_DEF + 6) + 16;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  cmd_t              cmd_i       = '0;
  logic              cfg_valid_i = 1'b0;
  logic [CFG_IW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0] cfg_data_i  = '0;
  logic              busy;
  rsp_t              res_o;
  logic              res_valid_o;
  logic              cfg_ready_o;
  int                fail_count;
  int                pending;

  int points_now = MAX_POINTS_DEF;
  int sent       = 0;
  bit idle_on    = 1'b1;
  bit held_once  = 1'b0;

  wave_heightfield_step uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  whs_checker watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd_i),
    .res_i        (res_o),
    .res_valid_i  (res_valid_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(64'd30_000_000);
    $display("** wave_heightfield_step: FAILED **");
    $finish;
  end

  // start stays high from one command transaction to the next unless maybe_idle or drain lowers it
  task automatic send_cmd(logic [1:0] m, logic [7:0] idx, logic [15:0] val, logic [15:0] dt);
    cmd_t c;
    c.mode  = m;
    c.index = idx;
    c.value = val;
    c.delta = dt;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_POINTS)
      points_now = (data[POINTS_W-1:0] < MIN_POINTS) ? MIN_POINTS :
                   (data[POINTS_W-1:0] > MAX_POINTS_DEF) ? MAX_POINTS_DEF :
                   int'(data[POINTS_W-1:0]);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic configure(logic [15:0] gain, logic [24:0] damp, logic [POINTS_W-1:0] pts);
    drain();
    set_reg(CFG_GAIN, CFG_DW'(gain));
    set_reg(CFG_DAMP, CFG_DW'(damp));
    set_reg(CFG_POINTS, CFG_DW'(pts));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_index();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(points_now - 1));
  endfunction

  function automatic logic [15:0] pick_height();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(8191)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_delta();
    if ($urandom_range(1) == 0) return 16'($urandom);
    return 16'($urandom_range(1024));
  endfunction

  task automatic random_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 40)
      send_cmd(MODE_WRITE, pick_index(), pick_height(), 16'($urandom));
    else if (r < 60)
      send_cmd(MODE_ADVANCE, 8'($urandom), 16'($urandom), pick_delta());
    else if (r < 95)
      send_cmd(MODE_READ, pick_index(), 16'($urandom), 16'($urandom));
    else
      send_cmd(MODE_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // bounded random profile over the whole field, one advance command, then read-back
  task automatic profile_sweep();
    int i;
    for (i = 0; i < points_now; i++)
      send_cmd(MODE_WRITE, 8'(i), 16'($urandom_range(4095)) - 16'd2048, 16'($urandom));
    send_cmd(MODE_ADVANCE, 8'($urandom), 16'($urandom), pick_delta());
    for (i = 0; i < points_now / 2; i++)
      send_cmd(MODE_READ, 8'($urandom_range(points_now - 1)), 16'($urandom), 16'($urandom));
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  initial begin
    int stop;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults, full field: ends, extremes and step sizes 256, 0xffff and 0
    send_cmd(MODE_WRITE, 8'd0, 16'h8000, 16'd0);
    send_cmd(MODE_WRITE, 8'd255, 16'h7fff, 16'hffff);
    send_cmd(MODE_WRITE, 8'd128, 16'h1000, 16'd0);
    send_cmd(MODE_WRITE, 8'd127, 16'hf000, 16'd0);
    send_cmd(MODE_WRITE, 8'd130, 16'h7fff, 16'd0);
    send_cmd(MODE_READ, 8'd0, 16'd0, 16'd0);
    send_cmd(MODE_READ, 8'd255, 16'd0, 16'd0);
    send_cmd(MODE_ADVANCE, 8'd0, 16'd0, 16'd256);
    send_cmd(MODE_READ, 8'd128, 16'd0, 16'd0);
    send_cmd(MODE_READ, 8'd129, 16'd0, 16'd0);
    send_cmd(MODE_ADVANCE, 8'hff, 16'hffff, 16'hffff);
    send_cmd(MODE_ADVANCE, 8'd0, 16'd0, 16'd0);
    send_cmd(MODE_READ, 8'd130, 16'd0, 16'd0);
    send_cmd(MODE_UNUSED, 8'hff, 16'hffff, 16'hffff);

    // smallest field, strongest coupling, damping above one, spare register
    configure(16'hffff, 25'h1ffffff, 9'd5);
    @(posedge clk_i);
    set_reg(CFG_SPARE, '1);
    cfg_valid_i <= 1'b0;
    send_cmd(MODE_WRITE, 8'd5, 16'h0001, 16'd0);
    send_cmd(MODE_READ, 8'd255, 16'd0, 16'd0);
    send_cmd(MODE_WRITE, 8'd2, 16'h7fff, 16'd0);
    send_cmd(MODE_WRITE, 8'd1, 16'h8000, 16'd0);
    send_cmd(MODE_WRITE, 8'd3, 16'h8000, 16'd0);
    send_cmd(MODE_ADVANCE, 8'd0, 16'd0, 16'hffff);
    send_cmd(MODE_READ, 8'd2, 16'd0, 16'd0);
    send_cmd(MODE_READ, 8'd4, 16'd0, 16'd0);

    // point count below the minimum
    configure(16'hffff, 25'h1ffffff, 9'd0);
    send_cmd(MODE_READ, 8'd4, 16'd0, 16'd0);
    send_cmd(MODE_READ, 8'd5, 16'd0, 16'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure(GAIN_RST, DAMP_RST, 9'($urandom_range(5, 24)));
        1: configure(16'($urandom), 25'($urandom), 9'($urandom_range(5, 40)));
        2: configure(16'd0, 25'd0, 9'd5);
        3: configure(16'hffff, DAMP_ONE, 9'd256);
        4: configure(16'($urandom), 25'($urandom_range(0, 16777216)), 9'd511);
        5: configure(16'($urandom), 25'($urandom), 9'($urandom_range(0, 4)));
        6: configure(16'($urandom), DAMP_ONE - 25'($urandom_range(4096)),
                     9'($urandom_range(5, 64)));
        default: configure(16'($urandom_range(8000)), 25'($urandom),
                           9'($urandom_range(5, 32)));
      endcase
      idle_on = (ph != PHASES - 1);
      stop = sent + PHASE_ITEMS;
      while (sent < stop) begin
        if (points_now <= 48 && $urandom_range(15) == 0)
          profile_sweep();
        else
          random_cmd();
        maybe_idle();
        if ((!held_once && ph == 1 && sent >= stop - 40) ||
            (idle_on && $urandom_range(63) == 0)) begin
          drain();
          held_once = 1'b1;
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("** wave_heightfield_step: PASSED **");
    else
      $display("** wave_heightfield_step: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
hdl/whs_pkg.sv
hdl/whs_field_mem.sv
hdl/whs_stencil_dp.sv
hdl/wave_heightfield_step.sv
verif/whs_checker.sv
verif/tb_wave_heightfield_step.sv
